/* src/smm_pkg.sv */
// Shared types and constants for the square matrix multiply block.
package smm_pkg;

    localparam int ELEM_W   = 16;
    localparam int IDX_FW   = 4;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 36;
    localparam int KIND_W   = 2;
    localparam int DIM_W    = 5;
    localparam int RES_CAP  = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROW_REQ = 2'd2;

    localparam logic [DIM_W-1:0] SIZE_RESET = 5'd16;

    typedef struct packed {
        logic valid;
        logic first_term;
        logic last_term;
    } mac_ctrl_t;

endpackage

/* src/smm_store.sv */
// Single-port-write, registered-read element store for one operand matrix.
module smm_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [smm_pkg::ELEM_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [smm_pkg::ELEM_W-1:0] rd_data
);
    import smm_pkg::*;

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/smm_mac.sv */
// Shared multiply-accumulate unit: one registered multiplier and one accumulator.
module smm_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  smm_pkg::mac_ctrl_t                ctrl,
    input  logic signed [smm_pkg::ELEM_W-1:0] a_data,
    input  logic signed [smm_pkg::ELEM_W-1:0] b_data,
    output logic                              done,
    output logic signed [smm_pkg::SUM_W-1:0]  sum
);
    import smm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctrl_t                ctrl_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic signed [SUM_W-1:0]  prod_ext;
    logic                     done_reg;

    assign prod_ext = SUM_W'(prod_reg);

    always_comb begin
        acc_next = acc_reg;
        if (ctrl_reg.valid) begin
            acc_next = ctrl_reg.first_term ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctrl_reg <= ctrl;
            done_reg <= ctrl_reg.valid & ctrl_reg.last_term;
        end
        prod_reg <= a_data * b_data;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

/* src/square_matrix_multiply.sv */
// Top level of the square matrix multiply block with its row sequencer.
//
// Usage: input beats arrive on the s_ channel. A load beat (kind 0 for A,
// kind 1 for B) writes one element. A row request beat (kind 2) for row r
// returns n result beats on the m_ channel, C[r][0] to C[r][n-1], the final
// one marked by m_tlast. A request for a row at or beyond n, and kind 3, give
// no beats. The dimension n must be written on the cfg_ channel only while
// the block is idle; the block itself does not enforce this. Zero counts as
// one and values above the store size are limited.
// One shared multiplier serves every product, so the columns of C are
// computed one after another and s_tready stays low until the whole row is
// done. Loads are accepted one per cycle while the block is idle.
// The output register lets the next column be computed while a result
// waits; if the receiver stalls, the sequencer holds until it is free.
// Reset empties the output and sets n to 16, and both ready outputs stay low
// while it is held; the stores are not cleared and must be loaded before
// they are used.
module square_matrix_multiply #(
    parameter int MAX_DIM = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row [3:0], col [7:4], value [23:8]
    input  logic [smm_pkg::S_TDATA_W-1:0] s_tdata,
    // kind [1:0]
    input  logic [smm_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_row [3:0], out_col [7:4], product_sum [43:8], zero [47:44]
    output logic [smm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smm_pkg::DIM_W-1:0]     cfg_data
);
    import smm_pkg::*;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DIM_CAP = (MAX_DIM < RES_CAP) ? MAX_DIM : RES_CAP;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [DIM_W-1:0]  size_reg;
    logic [IDX_FW-1:0] row_reg, row_next;
    logic [IDX_FW-1:0] c_reg, c_next;
    logic [IDX_FW-1:0] t_reg, t_next;
    mac_ctrl_t         issue_ctrl, rd_ctrl_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [IDX_FW-1:0] out_row_reg, out_col_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic              out_last_reg;
    logic              out_load;

    logic [DIM_W-1:0]  n_eff;
    logic [IDX_FW-1:0] n_top;
    logic              in_beat;
    logic [IDX_FW-1:0] in_row, in_col;
    logic [ELEM_W-1:0] in_value;
    logic              in_range;
    logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;
    logic              wr_a, wr_b;
    logic [ELEM_W-1:0] a_data, b_data;
    logic              mac_done;
    logic [SUM_W-1:0]  mac_sum;

    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_value = s_tdata[23:8];

    always_comb begin
        priority if (size_reg == '0) begin
            n_eff = DIM_W'(1);
        end else if (32'(size_reg) > DIM_CAP) begin
            n_eff = DIM_W'(DIM_CAP);
        end else begin
            n_eff = size_reg;
        end
    end

    assign n_top = IDX_FW'(n_eff - DIM_W'(1));

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign cfg_ready = aresetn;
    assign in_beat   = s_tvalid & s_tready;
    assign in_range  = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign wr_addr   = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
    assign wr_a      = in_beat && in_range && (s_tuser == KIND_LOAD_A);
    assign wr_b      = in_beat && in_range && (s_tuser == KIND_LOAD_B);

    assign a_addr = ADDR_W'(32'(row_reg) * MAX_DIM + 32'(t_reg));
    assign b_addr = ADDR_W'(32'(t_reg) * MAX_DIM + 32'(c_reg));

    assign issue_ctrl.valid      = (state_reg == ST_ISSUE);
    assign issue_ctrl.first_term = (t_reg == '0);
    assign issue_ctrl.last_term  = (t_reg == n_top);

    assign out_load = (state_reg == ST_HOLD) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        c_next     = c_reg;
        t_next     = t_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat && (s_tuser == KIND_ROW_REQ) && (DIM_W'(in_row) < n_eff)) begin
                    row_next   = in_row;
                    c_next     = '0;
                    t_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (t_reg == n_top) begin
                    t_next     = '0;
                    state_next = ST_WAIT;
                end else begin
                    t_next = t_reg + IDX_FW'(1);
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    if (c_reg == n_top) begin
                        state_next = ST_IDLE;
                    end else begin
                        c_next     = c_reg + IDX_FW'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            size_reg     <= SIZE_RESET;
            m_tvalid_reg <= 1'b0;
            rd_ctrl_reg  <= '0;
            row_reg      <= '0;
            c_reg        <= '0;
            t_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_ctrl_reg  <= issue_ctrl;
            row_reg      <= row_next;
            c_reg        <= c_next;
            t_reg        <= t_next;
            if (cfg_valid) begin
                size_reg <= cfg_data;
            end
        end
        if (out_load) begin
            out_row_reg  <= row_reg;
            out_col_reg  <= c_reg;
            out_sum_reg  <= mac_sum;
            out_last_reg <= (c_reg == n_top);
        end
    end

    smm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (a_addr),
        .rd_data (a_data)
    );

    smm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (b_addr),
        .rd_data (b_data)
    );

    smm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rd_ctrl_reg),
        .a_data  (a_data),
        .b_data  (b_data),
        .done    (mac_done),
        .sum     (mac_sum)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_sum_reg, out_col_reg, out_row_reg};

endmodule

/* tb/square_matrix_multiply_checker.sv */
// Checker that rebuilds each requested row of C from the observed beats and compares the results.
module square_matrix_multiply_checker #(
    parameter int MAX_DIM = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [smm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [smm_pkg::KIND_W-1:0]    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [smm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [smm_pkg::DIM_W-1:0]     cfg_data,
    output int                            c_elem_errors,
    output int                            c_elems_pending
);

    typedef struct packed {
        logic [3:0]                       row;
        logic [3:0]                       col;
        logic signed [smm_pkg::SUM_W-1:0] sum;
        logic                             last;
    } c_elem_t;

    localparam longint SUM_HI = (longint'(1) <<< (smm_pkg::SUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    logic [smm_pkg::ELEM_W-1:0] a_store [MAX_DIM*MAX_DIM];
    logic [smm_pkg::ELEM_W-1:0] b_store [MAX_DIM*MAX_DIM];
    logic [smm_pkg::DIM_W-1:0]  dim_reg = smm_pkg::SIZE_RESET;
    c_elem_t                    c_row_queue [$];
    int                         error_count = 0;

    function automatic int dim_in_effect(input logic [smm_pkg::DIM_W-1:0] setting);
        int n;
        n = int'(setting);
        if (n < 1) n = 1;
        if (n > MAX_DIM) n = MAX_DIM;
        if (n > smm_pkg::RES_CAP) n = smm_pkg::RES_CAP;
        return n;
    endfunction

    task automatic predict_c_row(input int r);
        int      n;
        longint  acc;
        c_elem_t elem;
        n = dim_in_effect(dim_reg);
        if (r >= n) return;
        for (int c = 0; c < n; c++) begin
            acc = 0;
            for (int t = 0; t < n; t++) begin
                acc += longint'($signed(a_store[r*MAX_DIM+t]))
                     * longint'($signed(b_store[t*MAX_DIM+c]));
            end
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
            elem.row  = 4'(r);
            elem.col  = 4'(c);
            elem.sum  = acc[smm_pkg::SUM_W-1:0];
            elem.last = (c == n - 1);
            c_row_queue.push_back(elem);
        end
    endtask

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endfunction

    always @(posedge aclk) begin
        c_elem_t got;
        c_elem_t want;
        int      r;
        int      c;
        if (!aresetn) begin
            c_row_queue.delete();
            dim_reg = smm_pkg::SIZE_RESET;
        end else begin
            if (cfg_valid && cfg_ready) dim_reg = cfg_data;
            if (m_tvalid && m_tready) begin
                got.row  = m_tdata[3:0];
                got.col  = m_tdata[7:4];
                got.sum  = m_tdata[43:8];
                got.last = m_tlast;
                if (c_row_queue.size() == 0) begin
                    note_error($sformatf("Unexpected result beat: row %0d col %0d sum %0d last %0b",
                                         got.row, got.col, got.sum, got.last));
                end else begin
                    want = c_row_queue.pop_front();
                    if (got.row !== want.row || got.col !== want.col ||
                        got.sum !== want.sum || got.last !== want.last) begin
                        note_error($sformatf({"Result mismatch: expected row %0d col %0d sum %0d",
                                              " last %0b, got row %0d col %0d sum %0d last %0b"},
                                             want.row, want.col, want.sum, want.last,
                                             got.row, got.col, got.sum, got.last));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                r = int'(s_tdata[3:0]);
                c = int'(s_tdata[7:4]);
                case (s_tuser)
                    smm_pkg::KIND_LOAD_A: begin
                        if (r < MAX_DIM && c < MAX_DIM) a_store[r*MAX_DIM+c] = s_tdata[23:8];
                    end
                    smm_pkg::KIND_LOAD_B: begin
                        if (r < MAX_DIM && c < MAX_DIM) b_store[r*MAX_DIM+c] = s_tdata[23:8];
                    end
                    smm_pkg::KIND_ROW_REQ: begin
                        predict_c_row(r);
                    end
                    default: begin
                    end
                endcase
            end
        end
        c_elem_errors   <= error_count;
        c_elems_pending <= c_row_queue.size();
    end

endmodule

/* tb/square_matrix_multiply_tb.sv */
// Testbench top: drives loads, row requests and size writes into the block and gives the verdict.
module square_matrix_multiply_tb;

    localparam int DIM_MAX       = 16;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 10;

    localparam logic [smm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [smm_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [smm_pkg::KIND_W-1:0]    s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [smm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [smm_pkg::DIM_W-1:0]     cfg_data  = '0;

    int   c_elem_errors;
    int   c_elems_pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_pending   = 1'b0;
    int   dim_now        = DIM_MAX;
    int   items_sent     = 0;
    bit   a_loaded [DIM_MAX*DIM_MAX];
    bit   b_loaded [DIM_MAX*DIM_MAX];

    square_matrix_multiply #(
        .MAX_DIM(DIM_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    square_matrix_multiply_checker #(
        .MAX_DIM(DIM_MAX)
    ) chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .c_elem_errors   (c_elem_errors),
        .c_elems_pending (c_elems_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver stalls at random, or holds off for a long stretch when asked.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending <= 1'b0;
                m_tready     <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_beat(input logic [smm_pkg::KIND_W-1:0] kind, input logic [3:0] r,
                             input logic [3:0] c, input logic [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {v, c, r};
        do @(posedge aclk); while (!s_tready);
        if (kind == smm_pkg::KIND_LOAD_A) a_loaded[int'(r)*DIM_MAX+int'(c)] = 1'b1;
        if (kind == smm_pkg::KIND_LOAD_B) b_loaded[int'(r)*DIM_MAX+int'(c)] = 1'b1;
        if (kind == smm_pkg::KIND_LOAD_A || kind == smm_pkg::KIND_LOAD_B ||
            (kind == smm_pkg::KIND_ROW_REQ && int'(r) < dim_now)) begin
            items_sent++;
        end
    endtask

    task automatic load_elem(input logic [smm_pkg::KIND_W-1:0] kind, input int r, input int c);
        logic [15:0] v;
        case ($urandom_range(7))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            default: v = 16'($urandom);
        endcase
        send_beat(kind, 4'(r), 4'(c), v);
    endtask

    // A request only goes out once every element of A and B that it reads has been loaded.
    task automatic request_row(input int r);
        if (r < dim_now) begin
            for (int t = 0; t < dim_now; t++) begin
                if (!a_loaded[r*DIM_MAX+t]) load_elem(smm_pkg::KIND_LOAD_A, r, t);
            end
            for (int t = 0; t < dim_now; t++) begin
                for (int c = 0; c < dim_now; c++) begin
                    if (!b_loaded[t*DIM_MAX+c]) load_elem(smm_pkg::KIND_LOAD_B, t, c);
                end
            end
        end
        send_beat(smm_pkg::KIND_ROW_REQ, 4'(r), 4'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (c_elems_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_dim(input logic [smm_pkg::DIM_W-1:0] setting);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= setting;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (setting == 0) dim_now = 1;
        else if (int'(setting) > DIM_MAX) dim_now = DIM_MAX;
        else dim_now = int'(setting);
    endtask

    task automatic random_phase(input logic [smm_pkg::DIM_W-1:0] setting, input int phase,
                                input bit with_hold);
        int goal;
        int pick;
        set_dim(setting);
        case (phase % 4)
            0: begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            1: begin
                send_idle_pct = 49;
                recv_stall_pct <= 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct <= 49;
            end
            default: begin
                send_idle_pct = 17;
                recv_stall_pct <= 17;
            end
        endcase
        if (with_hold) hold_pending <= 1'b1;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                request_row($urandom_range(dim_now - 1));
            end else if (pick < 85) begin
                load_elem($urandom_range(1) ? smm_pkg::KIND_LOAD_B : smm_pkg::KIND_LOAD_A,
                          $urandom_range(DIM_MAX - 1), $urandom_range(DIM_MAX - 1));
            end else if (pick < 92) begin
                send_beat(KIND_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom));
            end else if (dim_now < DIM_MAX) begin
                send_beat(smm_pkg::KIND_ROW_REQ, 4'($urandom_range(DIM_MAX - 1, dim_now)),
                          4'($urandom), 16'($urandom));
            end else begin
                request_row($urandom_range(dim_now - 1));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        set_dim(5'd2);
        send_beat(smm_pkg::KIND_LOAD_A, 4'd0, 4'd0, 16'h7fff);
        send_beat(smm_pkg::KIND_LOAD_A, 4'd0, 4'd1, 16'h8000);
        send_beat(smm_pkg::KIND_LOAD_A, 4'd1, 4'd0, 16'h8000);
        send_beat(smm_pkg::KIND_LOAD_A, 4'd1, 4'd1, 16'h8000);
        send_beat(smm_pkg::KIND_LOAD_B, 4'd0, 4'd0, 16'h7fff);
        send_beat(smm_pkg::KIND_LOAD_B, 4'd0, 4'd1, 16'h8000);
        send_beat(smm_pkg::KIND_LOAD_B, 4'd1, 4'd0, 16'h8000);
        send_beat(smm_pkg::KIND_LOAD_B, 4'd1, 4'd1, 16'h8000);
        request_row(0);
        request_row(1);
        send_beat(smm_pkg::KIND_LOAD_A, 4'd15, 4'd15, 16'hffff);
        send_beat(smm_pkg::KIND_LOAD_B, 4'd15, 4'd15, 16'h0000);
        send_beat(KIND_UNUSED, 4'hf, 4'hf, 16'hffff);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd15, 4'hf, 16'hffff);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd2, 4'h0, 16'h0000);

        set_dim(5'd0);
        request_row(0);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd1, 4'h0, 16'h0000);
        set_dim(5'd1);
        send_beat(smm_pkg::KIND_LOAD_A, 4'd0, 4'd0, 16'h0000);
        send_beat(smm_pkg::KIND_LOAD_B, 4'd0, 4'd0, 16'h0100);
        request_row(0);

        random_phase(5'd3, 0, 1'b0);
        random_phase(5'd1, 1, 1'b0);
        random_phase(5'd5, 2, 1'b0);
        random_phase(5'd4, 3, 1'b1);
        random_phase(5'd31, 4, 1'b0);
        random_phase(5'd2, 5, 1'b0);
        random_phase(5'd6, 6, 1'b0);
        random_phase(5'd16, 7, 1'b0);
        random_phase(5'd8, 8, 1'b0);
        random_phase(5'd0, 9, 1'b0);

        drain();
        repeat (100) @(posedge aclk);
        if (c_elem_errors == 0 && c_elems_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
